>>> design/met_pkg.sv
// Package for the escape-time pixel engine: widths, reset values, register
// indexes, controller states and the command/status structs.
// Used by met_ctrl, met_datapath and mandelbrot_escape_time_pixel.
package met_pkg;

    localparam int COORD_WIDTH_DEF     = 32;
    localparam int COORD_FRAC_BITS_DEF = 28;
    localparam int COUNT_WIDTH_DEF     = 16;
    localparam int DIM_WIDTH_DEF       = 12;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CENTER_W   = 32;
    localparam int STEP_W     = 31;
    localparam int MAX_ITER_W = 16;
    localparam int IMG_DIM_W  = 13;
    localparam int ADDR_W     = 24;

    localparam logic [CENTER_W-1:0]   CENTER_RST   = '0;
    localparam logic [STEP_W-1:0]     STEP_RST     = 31'd268435;
    localparam logic [MAX_ITER_W-1:0] MAX_ITER_RST = 16'd256;
    localparam logic [IMG_DIM_W-1:0]  IMG_DIM_RST  = 13'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_RE   = 3'd0,
        CFG_CENTER_IM   = 3'd1,
        CFG_STEP_RE     = 3'd2,
        CFG_STEP_IM     = 3'd3,
        CFG_MAX_ITER    = 3'd4,
        CFG_IMAGE_WIDTH = 3'd5,
        CFG_IMAGE_HEIGHT = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_ORIGIN,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic map;
        logic origin;
        logic mul;
        logic iterate;
        logic publish;
    } t_dp_cmd;

    typedef struct packed {
        logic at_limit;
        logic escaped;
        logic out_free;
    } t_dp_status;

endpackage

>>> design/mandelbrot_escape_time_pixel.sv
// Escape-time pixel engine, top level: controller plus datapath.
// A pixel is captured, mapped to the plane and iterated (multiply, then
// add/saturate/escape test) until it escapes or reaches max_iter; its result
// then waits for a free output register. One pixel at a time: a new input is
// taken only after the result transfer. Synchronous active-low reset; no clearing pass.
module mandelbrot_escape_time_pixel import met_pkg::*; #(
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int COUNT_WIDTH     = COUNT_WIDTH_DEF,
    parameter int DIM_WIDTH       = DIM_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [DIM_WIDTH-1:0]   i_col,
    input  logic [DIM_WIDTH-1:0]   i_row,
    input  logic                   i_frame_start,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [COUNT_WIDTH-1:0] o_iteration_count,
    output logic [ADDR_W-1:0]      o_pixel_address,
    output logic [COUNT_WIDTH-1:0] o_frame_min,
    output logic [COUNT_WIDTH-1:0] o_frame_max
);

    t_dp_cmd    cmd;
    t_dp_status status;

    met_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    met_datapath #(
        .COORD_WIDTH     (COORD_WIDTH),
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .COUNT_WIDTH     (COUNT_WIDTH),
        .DIM_WIDTH       (DIM_WIDTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_col             (i_col),
        .i_row             (i_row),
        .i_frame_start     (i_frame_start),
        .i_out_stall       (i_out_stall),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_out_valid       (o_out_valid),
        .o_iteration_count (o_iteration_count),
        .o_pixel_address   (o_pixel_address),
        .o_frame_min       (o_frame_min),
        .o_frame_max       (o_frame_max)
    );

endmodule

>>> design/met_ctrl.sv
// Controller of the escape-time pixel engine: sequences mapping, the
// multiply/add iteration loop and result transfer. Depends on met_pkg.
module met_ctrl import met_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_MAP;
                end
            end
            ST_MAP: begin
                o_cmd.map = 1'b1;
                n_state   = ST_ORIGIN;
            end
            ST_ORIGIN: begin
                o_cmd.origin = 1'b1;
                n_state      = ST_MUL;
            end
            ST_MUL: begin
                if (i_status.at_limit) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = ST_ADD;
                end
            end
            ST_ADD: begin
                if (i_status.escaped) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.iterate = 1'b1;
                    n_state       = ST_MUL;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |-> i_status.out_free)
        else $error("result transfer while output register busy");

    a_capture_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> r_state == ST_MAP)
        else $error("capture not followed by mapping");

    a_escape_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD && i_status.escaped) |=> r_state == ST_DONE)
        else $error("escape did not end the iteration");

    a_limit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL && i_status.at_limit) |=> r_state == ST_DONE)
        else $error("limit did not end the iteration");

endmodule

>>> design/met_datapath.sv
// Datapath of the escape-time pixel engine: configuration registers,
// coordinate mapping, z*z + c iteration, address and running min/max.
// Depends on met_pkg.
module met_datapath import met_pkg::*; #(
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int COUNT_WIDTH     = COUNT_WIDTH_DEF,
    parameter int DIM_WIDTH       = DIM_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [DIM_WIDTH-1:0]   i_col,
    input  logic [DIM_WIDTH-1:0]   i_row,
    input  logic                   i_frame_start,
    input  logic                   i_out_stall,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    output logic                   o_out_valid,
    output logic [COUNT_WIDTH-1:0] o_iteration_count,
    output logic [ADDR_W-1:0]      o_pixel_address,
    output logic [COUNT_WIDTH-1:0] o_frame_min,
    output logic [COUNT_WIDTH-1:0] o_frame_max
);

    localparam int W      = COORD_WIDTH;
    localparam int F      = COORD_FRAC_BITS;
    localparam int OFS_W  = ((DIM_WIDTH + 1 > IMG_DIM_W) ? DIM_WIDTH + 1 : IMG_DIM_W) + 1;
    localparam int PW     = OFS_W + STEP_W + 1;
    localparam int SW0    = (PW > CENTER_W) ? PW : CENTER_W;
    localparam int SW     = ((SW0 > W) ? SW0 : W) + 1;
    localparam int IW     = 2 * W + 2;
    localparam int AW     = ((DIM_WIDTH + IMG_DIM_W + 1) > ADDR_W) ?
                            (DIM_WIDTH + IMG_DIM_W + 1) : ADDR_W;
    localparam int CEXT_W = COUNT_WIDTH + MAX_ITER_W;
    localparam logic [2*W:0]       ESC_LIM  = {{(2*W){1'b0}}, 1'b1} << (2 * F + 2);
    localparam logic [CEXT_W-1:0]  MIN_RST  = CEXT_W'(MAX_ITER_RST);

    logic signed [CENTER_W-1:0]  r_center_re, r_center_im;
    logic [STEP_W-1:0]           r_step_re, r_step_im;
    logic [MAX_ITER_W-1:0]       r_max_iter;
    logic [IMG_DIM_W-1:0]        r_img_w, r_img_h;

    logic [DIM_WIDTH-1:0]        r_col, r_row;
    logic                        r_fs;
    logic signed [PW-1:0]        r_prod_re, r_prod_im;
    logic [ADDR_W-1:0]           r_addr;
    logic signed [W-1:0]         r_cr, r_ci, r_zr, r_zi;
    logic signed [2*W-1:0]       r_sr, r_si, r_pp;
    logic [MAX_ITER_W-1:0]       r_n;
    logic                        r_out_valid;
    logic [COUNT_WIDTH-1:0]      r_out_cnt;
    logic [ADDR_W-1:0]           r_out_addr;
    logic [COUNT_WIDTH-1:0]      r_min, r_max;

    logic signed [OFS_W-1:0]     ofs_re, ofs_im;
    logic signed [PW-1:0]        n_prod_re, n_prod_im;
    logic signed [PW-1:0]        half_re, half_im;
    logic signed [SW-1:0]        map_re, map_im;
    logic [AW-1:0]               addr_full;
    logic signed [2*W-1:0]       n_sr, n_si, n_pp;
    logic [2*W:0]                mag;
    logic signed [2*W:0]         re_full, re_sh;
    logic signed [IW-1:0]        im_full, im_sh;
    logic signed [IW-1:0]        sum_re, sum_im;
    logic [CEXT_W-1:0]           cnt_ext, lim_ext;
    logic [COUNT_WIDTH-1:0]      cnt_c, lim_c, base_min, base_max;

    function automatic logic signed [W-1:0] sat_map(input logic signed [SW-1:0] x);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
        lo = ~hi;
        if (x > hi) begin
            return hi[W-1:0];
        end else if (x < lo) begin
            return lo[W-1:0];
        end
        return x[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat_iter(input logic signed [IW-1:0] x);
        logic signed [IW-1:0] hi;
        logic signed [IW-1:0] lo;
        hi = {{(IW-W+1){1'b0}}, {(W-1){1'b1}}};
        lo = ~hi;
        if (x > hi) begin
            return hi[W-1:0];
        end else if (x < lo) begin
            return lo[W-1:0];
        end
        return x[W-1:0];
    endfunction

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_re <= CENTER_RST;
            r_center_im <= CENTER_RST;
            r_step_re   <= STEP_RST;
            r_step_im   <= STEP_RST;
            r_max_iter  <= MAX_ITER_RST;
            r_img_w     <= IMG_DIM_RST;
            r_img_h     <= IMG_DIM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CENTER_RE:    r_center_re <= i_cfg_data[CENTER_W-1:0];
                CFG_CENTER_IM:    r_center_im <= i_cfg_data[CENTER_W-1:0];
                CFG_STEP_RE:      r_step_re   <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_IM:      r_step_im   <= i_cfg_data[STEP_W-1:0];
                CFG_MAX_ITER:     r_max_iter  <= i_cfg_data[MAX_ITER_W-1:0];
                CFG_IMAGE_WIDTH:  r_img_w     <= i_cfg_data[IMG_DIM_W-1:0];
                CFG_IMAGE_HEIGHT: r_img_h     <= i_cfg_data[IMG_DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // coordinate mapping
    assign ofs_re = $signed({{(OFS_W-DIM_WIDTH-1){1'b0}}, r_col, 1'b0})
                  - $signed({{(OFS_W-IMG_DIM_W){1'b0}}, r_img_w});
    assign ofs_im = $signed({{(OFS_W-DIM_WIDTH-1){1'b0}}, r_row, 1'b0})
                  - $signed({{(OFS_W-IMG_DIM_W){1'b0}}, r_img_h});
    assign n_prod_re = ofs_re * $signed({1'b0, r_step_re});
    assign n_prod_im = ofs_im * $signed({1'b0, r_step_im});
    assign addr_full = AW'(r_col) + AW'(r_row) * AW'(r_img_w);

    assign half_re = r_prod_re >>> 1;
    assign half_im = r_prod_im >>> 1;
    assign map_re  = $signed({{(SW-PW){half_re[PW-1]}}, half_re})
                   + $signed({{(SW-CENTER_W){r_center_re[CENTER_W-1]}}, r_center_re});
    assign map_im  = $signed({{(SW-PW){half_im[PW-1]}}, half_im})
                   + $signed({{(SW-CENTER_W){r_center_im[CENTER_W-1]}}, r_center_im});

    // iteration
    assign n_sr = r_zr * r_zr;
    assign n_si = r_zi * r_zi;
    assign n_pp = r_zr * r_zi;

    assign mag     = {1'b0, r_sr} + {1'b0, r_si};
    assign re_full = {r_sr[2*W-1], r_sr} - {r_si[2*W-1], r_si};
    assign re_sh   = re_full >>> F;
    assign im_full = {{2{r_pp[2*W-1]}}, r_pp};
    assign im_sh   = im_full >>> (F - 1);
    assign sum_re  = {re_sh[2*W], re_sh} + {{(W+2){r_cr[W-1]}}, r_cr};
    assign sum_im  = im_sh + {{(W+2){r_ci[W-1]}}, r_ci};

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_col <= i_col;
            r_row <= i_row;
            r_fs  <= i_frame_start;
        end
        if (i_cmd.map) begin
            r_prod_re <= n_prod_re;
            r_prod_im <= n_prod_im;
            r_addr    <= addr_full[ADDR_W-1:0];
        end
        if (i_cmd.origin) begin
            r_cr <= sat_map(map_re);
            r_ci <= sat_map(map_im);
            r_zr <= '0;
            r_zi <= '0;
            r_n  <= '0;
        end
        if (i_cmd.mul) begin
            r_sr <= n_sr;
            r_si <= n_si;
            r_pp <= n_pp;
        end
        if (i_cmd.iterate) begin
            r_zr <= sat_iter(sum_re);
            r_zi <= sat_iter(sum_im);
            r_n  <= r_n + 1'b1;
        end
        if (i_cmd.publish) begin
            r_out_cnt  <= cnt_c;
            r_out_addr <= r_addr;
        end
    end

    // result and running min/max
    assign cnt_ext  = {{COUNT_WIDTH{1'b0}}, r_n};
    assign lim_ext  = {{COUNT_WIDTH{1'b0}}, r_max_iter};
    assign cnt_c    = cnt_ext[COUNT_WIDTH-1:0];
    assign lim_c    = lim_ext[COUNT_WIDTH-1:0];
    assign base_min = r_fs ? lim_c : r_min;
    assign base_max = r_fs ? '0 : r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_min       <= MIN_RST[COUNT_WIDTH-1:0];
            r_max       <= '0;
        end else begin
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
                r_min       <= (cnt_c < base_min) ? cnt_c : base_min;
                r_max       <= (cnt_c > base_max) ? cnt_c : base_max;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.at_limit = (r_n == r_max_iter);
    assign o_status.escaped  = (mag > ESC_LIM);
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid       = r_out_valid;
    assign o_iteration_count = r_out_cnt;
    assign o_pixel_address   = r_out_addr;
    assign o_frame_min       = r_min;
    assign o_frame_max       = r_max;

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_frame_min <= o_frame_max)
        else $error("frame minimum above frame maximum");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.iterate |-> r_n != r_max_iter)
        else $error("iteration past the limit");

endmodule

>>> verif/mandelbrot_escape_time_pixel_tb.sv
// Self-checking testbench for mandelbrot_escape_time_pixel: drives pixel transfers,
// predicts escape counts, addresses and frame min/max, and checks every result.
// Depends on met_pkg and the top level of the design.
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_tb;
    import met_pkg::*;

    localparam int CW           = COORD_WIDTH_DEF;
    localparam int FRAC         = COORD_FRAC_BITS_DEF;
    localparam int CNT_W        = COUNT_WIDTH_DEF;
    localparam int DIM_W        = DIM_WIDTH_DEF;
    localparam int WIDE         = 72;
    localparam int TOTAL_PIXELS = 1650;
    localparam int STALL_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [WIDE-1:0] ESCAPE_BOUND = 72'sd1 <<< (2 * FRAC + 2);

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  fmin;
        logic [CNT_W-1:0]  fmax;
    } t_pixel_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [DIM_W-1:0]      i_col;
    logic [DIM_W-1:0]      i_row;
    logic                  i_frame_start;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [CNT_W-1:0]      o_iteration_count;
    logic [ADDR_W-1:0]     o_pixel_address;
    logic [CNT_W-1:0]      o_frame_min;
    logic [CNT_W-1:0]      o_frame_max;

    logic signed [CW-1:0]  view_centre_re;
    logic signed [CW-1:0]  view_centre_im;
    logic [STEP_W-1:0]     view_step_re;
    logic [STEP_W-1:0]     view_step_im;
    logic [MAX_ITER_W-1:0] view_max_iter;
    logic [IMG_DIM_W-1:0]  view_width;
    logic [IMG_DIM_W-1:0]  view_height;
    logic [CNT_W-1:0]      run_min;
    logic [CNT_W-1:0]      run_max;

    t_pixel_result pending_pixels[$];
    t_pixel_result want;
    bit            no_idle;
    int            pixels_sent;
    int            results_checked;
    int            mismatches;
    int            reg_writes;
    int            views;
    int            quiet_cycles;

    mandelbrot_escape_time_pixel uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_col             (i_col),
        .i_row             (i_row),
        .i_frame_start     (i_frame_start),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_iteration_count (o_iteration_count),
        .o_pixel_address   (o_pixel_address),
        .o_frame_min       (o_frame_min),
        .o_frame_max       (o_frame_max)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [CW-1:0] clamp_coord(input logic signed [WIDE-1:0] v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v[CW-1:0];
    endfunction

    function automatic logic signed [CW-1:0] plane_coord(input logic signed [CW-1:0] centre,
                                                         input logic [STEP_W-1:0] step,
                                                         input logic [DIM_W-1:0] k,
                                                         input logic [IMG_DIM_W-1:0] n);
        logic signed [WIDE-1:0] kk, nn, ss, span;
        kk = WIDE'(k);
        nn = WIDE'(n);
        ss = WIDE'(step);
        span = (2 * kk - nn) * ss;
        span = span >>> 1;
        return clamp_coord(span + centre);
    endfunction

    function automatic logic [CNT_W-1:0] escape_iterations(input logic signed [CW-1:0] cr,
                                                           input logic signed [CW-1:0] ci,
                                                           input logic [MAX_ITER_W-1:0] limit);
        logic signed [WIDE-1:0] zr, zi, sr, si, zx;
        int n;
        zr = '0;
        zi = '0;
        for (n = 0; n < limit; n++) begin
            sr = zr * zr;
            si = zi * zi;
            if (sr + si > ESCAPE_BOUND) return n[CNT_W-1:0];
            zx = zr * zi;
            zr = WIDE'(clamp_coord(((sr - si) >>> FRAC) + cr));
            zi = WIDE'(clamp_coord((zx >>> (FRAC - 1)) + ci));
        end
        return limit;
    endfunction

    task automatic predict_pixel(input logic [DIM_W-1:0] col, input logic [DIM_W-1:0] row,
                                 input logic fs);
        t_pixel_result r;
        logic [31:0] c32, r32, w32, addr;
        logic [CNT_W-1:0] n;
        if (fs) begin
            run_min = view_max_iter;
            run_max = '0;
        end
        n = escape_iterations(plane_coord(view_centre_re, view_step_re, col, view_width),
                              plane_coord(view_centre_im, view_step_im, row, view_height),
                              view_max_iter);
        if (n < run_min) run_min = n;
        if (n > run_max) run_max = n;
        c32 = 32'(col);
        r32 = 32'(row);
        w32 = 32'(view_width);
        addr = c32 + r32 * w32;
        r.count = n;
        r.addr = addr[ADDR_W-1:0];
        r.fmin = run_min;
        r.fmax = run_max;
        pending_pixels.push_back(r);
    endtask

    task automatic send_pixel(input logic [DIM_W-1:0] col, input logic [DIM_W-1:0] row,
                              input logic fs);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(0, 99) < 8) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_col         = col;
        i_row         = row;
        i_frame_start = fs;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        predict_pixel(col, row, fs);
        pixels_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_in_valid  = 1'b0;
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_CENTER_RE:    view_centre_re = data;
            CFG_CENTER_IM:    view_centre_im = data;
            CFG_STEP_RE:      view_step_re   = data[STEP_W-1:0];
            CFG_STEP_IM:      view_step_im   = data[STEP_W-1:0];
            CFG_MAX_ITER:     view_max_iter  = data[MAX_ITER_W-1:0];
            CFG_IMAGE_WIDTH:  view_width     = data[IMG_DIM_W-1:0];
            CFG_IMAGE_HEIGHT: view_height    = data[IMG_DIM_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic random_view();
        int w, h, zoom;
        logic [31:0] sre, sim, iter;
        views++;
        if ($urandom_range(0, 9) == 0) begin
            write_reg(CFG_CENTER_RE, $urandom());
            write_reg(CFG_CENTER_IM, $urandom());
            write_reg(CFG_STEP_RE, $urandom());
            write_reg(CFG_STEP_IM, $urandom());
            write_reg(CFG_IMAGE_WIDTH, $urandom());
            write_reg(CFG_IMAGE_HEIGHT, $urandom());
            iter = $urandom_range(0, 40);
            write_reg(CFG_MAX_ITER, ($urandom() & 32'hFFFF_0000) | iter);
        end else begin
            w = $urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(17, 4096);
            h = $urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(17, 4096);
            zoom = $urandom_range(0, 6);
            sre = ((3 << FRAC) / w) >> zoom;
            sim = ((2 << FRAC) / h) >> zoom;
            write_reg(CFG_CENTER_RE, $urandom_range(0, 3 << FRAC) - (2 << FRAC));
            write_reg(CFG_CENTER_IM, $urandom_range(0, 2 << FRAC) - (1 << FRAC));
            write_reg(CFG_STEP_RE, sre | ($urandom_range(0, 1) << 31));
            write_reg(CFG_STEP_IM, sim | ($urandom_range(0, 1) << 31));
            write_reg(CFG_IMAGE_WIDTH, ($urandom() & 32'hFFFF_E000) | w);
            write_reg(CFG_IMAGE_HEIGHT, ($urandom() & 32'hFFFF_E000) | h);
            case ($urandom_range(0, 15))
                0:       iter = 0;
                1, 2:    iter = 256;
                default: iter = $urandom_range(1, 64);
            endcase
            write_reg(CFG_MAX_ITER, iter);
        end
    endtask

    task automatic scan_window(input bit new_frame);
        int sw, sh, c0, r0, lim, x, y;
        sw = $urandom_range(1, 10);
        sh = $urandom_range(1, 6);
        lim = (view_width >= sw && view_width <= 4096) ? view_width - sw : 4096 - sw;
        c0 = $urandom_range(0, lim);
        lim = (view_height >= sh && view_height <= 4096) ? view_height - sh : 4096 - sh;
        r0 = $urandom_range(0, lim);
        for (y = 0; y < sh; y++)
            for (x = 0; x < sw; x++)
                send_pixel(DIM_W'(c0 + x), DIM_W'(r0 + y), new_frame && x == 0 && y == 0);
    endtask

    task automatic test_reset_state();
        send_pixel(12'd512, 12'd512, 1'b0);
        send_pixel(12'd0, 12'd0, 1'b0);
        send_pixel(12'd4095, 12'd4095, 1'b0);
        wait_for_results();
    endtask

    task automatic test_zero_limit();
        write_reg(CFG_MAX_ITER, 32'hFFFF_0000);
        write_reg(CFG_IDX_UNUSED, $urandom());
        send_pixel(12'd100, 12'd200, 1'b1);
        send_pixel(12'd4095, 12'd0, 1'b0);
        wait_for_results();
    endtask

    task automatic test_extreme_view();
        write_reg(CFG_MAX_ITER, 32'd24);
        write_reg(CFG_CENTER_RE, 32'h7FFF_FFFF);
        write_reg(CFG_CENTER_IM, 32'h8000_0000);
        write_reg(CFG_STEP_RE, 32'hFFFF_FFFF);
        write_reg(CFG_STEP_IM, 32'h7FFF_FFFF);
        write_reg(CFG_IMAGE_WIDTH, 32'hFFFF_FFFF);
        write_reg(CFG_IMAGE_HEIGHT, 32'd0);
        send_pixel(12'd0, 12'd0, 1'b1);
        send_pixel(12'd4095, 12'd4095, 1'b0);
        send_pixel(12'd4095, 12'd0, 1'b0);
        wait_for_results();
        write_reg(CFG_IMAGE_WIDTH, 32'd0);
        write_reg(CFG_IMAGE_HEIGHT, 32'd3);
        write_reg(CFG_CENTER_RE, 32'd0);
        write_reg(CFG_CENTER_IM, 32'd0);
        write_reg(CFG_STEP_RE, 32'd0);
        write_reg(CFG_STEP_IM, 32'd0);
        send_pixel(12'd4095, 12'd4095, 1'b1);
        send_pixel(12'd1, 12'd2, 1'b0);
        wait_for_results();
        write_reg(CFG_STEP_RE, 32'd1);
        write_reg(CFG_STEP_IM, 32'd1);
        write_reg(CFG_CENTER_RE, 32'h8000_0000);
        write_reg(CFG_CENTER_IM, 32'h8000_0000);
        write_reg(CFG_IMAGE_WIDTH, 32'd4096);
        write_reg(CFG_IMAGE_HEIGHT, 32'd4096);
        send_pixel(12'd0, 12'd0, 1'b1);
        send_pixel(12'd2048, 12'd4095, 1'b0);
        wait_for_results();
    endtask

    task automatic test_long_limit();
        write_reg(CFG_CENTER_RE, 32'd0);
        write_reg(CFG_CENTER_IM, 32'd0);
        write_reg(CFG_STEP_RE, 32'd1 << FRAC);
        write_reg(CFG_STEP_IM, 32'd1 << FRAC);
        write_reg(CFG_IMAGE_WIDTH, 32'd1024);
        write_reg(CFG_IMAGE_HEIGHT, 32'd1024);
        write_reg(CFG_MAX_ITER, 32'd65535);
        send_pixel(12'd512, 12'd512, 1'b1);
        send_pixel(12'd0, 12'd0, 1'b0);
        wait_for_results();
        // lower the limit mid-frame: running min and max carry on
        write_reg(CFG_MAX_ITER, 32'd5);
        send_pixel(12'd512, 12'd512, 1'b0);
        wait_for_results();
    endtask

    task automatic test_back_to_back();
        int x, y;
        no_idle = 1'b1;
        random_view();
        for (y = 0; y < 6; y++)
            for (x = 0; x < 10; x++)
                send_pixel(DIM_W'(x), DIM_W'(y), x == 0 && y == 0);
        wait_for_results();
        no_idle = 1'b0;
    endtask

    task automatic test_random_frames();
        while (pixels_sent < TOTAL_PIXELS) begin
            random_view();
            if ($urandom_range(0, 4) == 0) begin
                repeat (20)
                    send_pixel(DIM_W'($urandom_range(0, 4095)),
                               DIM_W'($urandom_range(0, 4095)),
                               $urandom_range(0, 9) == 0);
            end else begin
                scan_window($urandom_range(0, 9) < 7);
            end
            wait_for_results();
        end
    endtask

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall = !no_idle && ($urandom_range(0, 99) < 8);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_checked++;
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: unexpected result count=%0d addr=%0d min=%0d max=%0d",
                             o_iteration_count, o_pixel_address, o_frame_min, o_frame_max);
            end else begin
                want = pending_pixels.pop_front();
                if (o_iteration_count !== want.count || o_pixel_address !== want.addr ||
                    o_frame_min !== want.fmin || o_frame_max !== want.fmax) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $write("ERROR: result %0d: count exp %0d got %0d, addr exp %0d got %0d,",
                               results_checked, want.count, o_iteration_count,
                               want.addr, o_pixel_address);
                        $display(" min exp %0d got %0d, max exp %0d got %0d",
                                 want.fmin, o_frame_min, want.fmax, o_frame_max);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_CENTER_RE;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_col           = '0;
        i_row           = '0;
        i_frame_start   = 1'b0;
        no_idle         = 1'b0;
        pixels_sent     = 0;
        results_checked = 0;
        mismatches      = 0;
        reg_writes      = 0;
        views           = 0;
        quiet_cycles    = 0;
        view_centre_re  = CENTER_RST;
        view_centre_im  = CENTER_RST;
        view_step_re    = STEP_RST;
        view_step_im    = STEP_RST;
        view_max_iter   = MAX_ITER_RST;
        view_width      = IMG_DIM_RST;
        view_height     = IMG_DIM_RST;
        run_min         = MAX_ITER_RST;
        run_max         = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_zero_limit();
        test_extreme_view();
        test_long_limit();
        test_back_to_back();
        test_random_frames();

        wait_for_results();
        repeat (64) @(posedge i_clk);
        $display("Covered %0d pixels over %0d random views with %0d register writes;",
                 pixels_sent, views, reg_writes);
        $display("%0d results compared, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
design/met_pkg.sv
design/met_ctrl.sv
design/met_datapath.sv
design/mandelbrot_escape_time_pixel.sv
verif/mandelbrot_escape_time_pixel_tb.sv
